// ===== hdl/box_muller_gaussian_noise_defines.svh =====
// assertion macros shared by the checker
`ifndef BOX_MULLER_GAUSSIAN_NOISE_DEFINES_SVH
`define BOX_MULLER_GAUSSIAN_NOISE_DEFINES_SVH

// consequent in the next cycle, held off during reset
`define BMG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("box_muller_gaussian_noise: assertion failed");

// consequent in the same cycle, held off during reset
`define BMG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("box_muller_gaussian_noise: assertion failed");

// consequent in the next cycle, checked through reset too
`define BMG_ASSERT_NEXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("box_muller_gaussian_noise: assertion failed");

`endif

// ===== hdl/bmg_pkg.sv =====
package bmg_pkg;

    localparam int M_TDATA_W = 24;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W = 20;
    localparam int SAMPLE_W = 20;

    localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_MEAN = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NOISE_SDEV = 8'd1;

    localparam logic [19:0] MEAN_RESET = 20'd0;
    localparam logic [15:0] SDEV_RESET = 16'd2048;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [29:0] Q30_HALF = 30'h2000_0000;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;
    localparam logic [30:0] PIH_Q30 = 31'd1686629713;

    localparam logic signed [21:0] SAMPLE_MAX = 22'sd524287;
    localparam logic signed [21:0] SAMPLE_MIN = -22'sd524288;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } bmg_quad_t;

    typedef struct packed {
        logic               vld;
        logic [31:0]        xn;
        logic [4:0]         zc;
        logic [30:0]        lm;
        logic [34:0]        lres;
        bmg_quad_t          quad;
        logic               swp;
        logic [29:0]        g;
        logic [29:0]        x;
        logic [29:0]        x2;
        logic [34:0]        lv;
        logic [35:0]        vi;
        logic [60:0]        vf;
        logic [53:0]        sn;
        logic [53:0]        sr;
        logic [30:0]        ts;
        logic [30:0]        tc;
        logic signed [31:0] s;
        logic signed [31:0] c;
        logic [30:0]        cmag;
        logic [30:0]        smag;
        logic               cneg;
        logic               sneg;
        logic [27:0]        cm;
        logic [27:0]        sm;
        logic [43:0]        wcos;
        logic [43:0]        wsin;
    } bmg_pipe_t;

    // log2 in q30 with squaring steps, used at elaboration for the full-scale code
    function automatic logic [34:0] log2_q30(input logic [31:0] x);
        logic [4:0]  e;
        logic [63:0] m;
        logic [34:0] res;
        e = '0;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) begin
                e = 5'(i);
            end
        end
        if (e <= 5'd30) begin
            m = 64'(x) << (5'd30 - e);
        end else begin
            m = 64'(x) >> 1;
        end
        res = {e, 30'd0};
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/bmg_log_cell.sv =====
module bmg_log_cell #(
    parameter int FRAC_BIT = 29
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  bmg_pkg::bmg_pipe_t  pipe_i,
    output bmg_pkg::bmg_pipe_t  pipe_o
);

    bmg_pkg::bmg_pipe_t pipe_reg;
    bmg_pkg::bmg_pipe_t pipe_next;
    logic [61:0] prod;
    logic [31:0] sq;

    always_comb begin
        prod = 62'(pipe_i.lm) * 62'(pipe_i.lm);
        sq = prod[61:30];
        pipe_next = pipe_i;
        if (sq[31]) begin
            pipe_next.lm = sq[31:1];
            pipe_next.lres[FRAC_BIT] = 1'b1;
        end else begin
            pipe_next.lm = sq[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_reg.vld <= 1'b0;
        end else if (adv) begin
            pipe_reg <= pipe_next;
        end
    end

    assign pipe_o = pipe_reg;

endmodule

// ===== hdl/bmg_sqrt_cell.sv =====
module bmg_sqrt_cell #(
    parameter int BIT_POS = 52
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  bmg_pkg::bmg_pipe_t  pipe_i,
    output bmg_pkg::bmg_pipe_t  pipe_o
);

    localparam logic [53:0] BIT_VAL = 54'(1) << BIT_POS;

    bmg_pkg::bmg_pipe_t pipe_reg;
    bmg_pkg::bmg_pipe_t pipe_next;
    logic [54:0] trial;

    always_comb begin
        trial = 55'(pipe_i.sr) + 55'(BIT_VAL);
        pipe_next = pipe_i;
        if (55'(pipe_i.sn) >= trial) begin
            pipe_next.sn = 54'(55'(pipe_i.sn) - trial);
            pipe_next.sr = (pipe_i.sr >> 1) + BIT_VAL;
        end else begin
            pipe_next.sr = pipe_i.sr >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pipe_reg.vld <= 1'b0;
        end else if (adv) begin
            pipe_reg <= pipe_next;
        end
    end

    assign pipe_o = pipe_reg;

endmodule

// ===== hdl/bmg_taylor_cell.sv =====
module bmg_taylor_cell #(
    parameter int unsigned SIN_DIV  = 6,
    parameter int unsigned COS_DIV  = 2,
    parameter bit          SUBTRACT = 1'b1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  bmg_pkg::bmg_pipe_t  pipe_i,
    output bmg_pkg::bmg_pipe_t  pipe_o
);

    localparam logic [31:0] SIN_RECIP = 32'(64'h1_0000_0000 / SIN_DIV);
    localparam logic [31:0] COS_RECIP = 32'(64'h1_0000_0000 / COS_DIV);

    bmg_pkg::bmg_pipe_t pa_reg, pb_reg, pc_reg;
    bmg_pkg::bmg_pipe_t pc_next;
    logic [29:0] sa_reg, ca_reg, sa_next, ca_next;
    logic [29:0] sb_reg, cb_reg;
    logic [29:0] sq_reg, cq_reg, sq_next, cq_next;
    logic [60:0] sprod, cprod;
    logic [61:0] srec, crec;
    logic [37:0] sback, cback, srem, crem;
    logic [29:0] sfix, cfix;

    // term times x squared
    always_comb begin
        sprod = 61'(pipe_i.ts) * 61'(pipe_i.x2);
        cprod = 61'(pipe_i.tc) * 61'(pipe_i.x2);
        sa_next = sprod[59:30];
        ca_next = cprod[59:30];
    end

    // reciprocal estimate of the quotient
    always_comb begin
        srec = 62'(sa_reg) * 62'(SIN_RECIP);
        crec = 62'(ca_reg) * 62'(COS_RECIP);
        sq_next = srec[61:32];
        cq_next = crec[61:32];
    end

    // one-step correction and accumulate
    always_comb begin
        sback = 38'(sq_reg) * 38'(SIN_DIV);
        cback = 38'(cq_reg) * 38'(COS_DIV);
        srem = 38'(sb_reg) - sback;
        crem = 38'(cb_reg) - cback;
        sfix = (srem >= 38'(SIN_DIV)) ? sq_reg + 30'd1 : sq_reg;
        cfix = (crem >= 38'(COS_DIV)) ? cq_reg + 30'd1 : cq_reg;
        pc_next = pb_reg;
        pc_next.ts = 31'(sfix);
        pc_next.tc = 31'(cfix);
        if (SUBTRACT) begin
            pc_next.s = pb_reg.s - 32'(sfix);
            pc_next.c = pb_reg.c - 32'(cfix);
        end else begin
            pc_next.s = pb_reg.s + 32'(sfix);
            pc_next.c = pb_reg.c + 32'(cfix);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_reg.vld <= 1'b0;
            pb_reg.vld <= 1'b0;
            pc_reg.vld <= 1'b0;
        end else if (adv) begin
            pa_reg <= pipe_i;
            pb_reg <= pa_reg;
            pc_reg <= pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sa_reg <= sa_next;
            ca_reg <= ca_next;
            sb_reg <= sa_reg;
            cb_reg <= ca_reg;
            sq_reg <= sq_next;
            cq_reg <= cq_next;
        end
    end

    assign pipe_o = pc_reg;

endmodule

// ===== hdl/box_muller_gaussian_noise.sv =====
// an accepted input passes the input, normalize, log, -ln, sqrt, Taylor, fold and product
// registers to the output register, showing the cosine sample on m_tdata; the sine sample
// follows in the next cycle when m_tready is high; the single result channel carries two
// samples per pair, so a full pipeline takes a new pair only as the sine sample leaves;
// rejected pairs (u1 zero) give no output; reset: synchronous active-low aresetn empties
// the pipeline and output register and sets noise_mean to 0 and noise_sdev to 2048
module box_muller_gaussian_noise #(
    parameter int UNIFORM_BITS = 16,
    localparam int S_TDATA_W = ((2 * UNIFORM_BITS + 7) / 8) * 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [S_TDATA_W-1:0]                s_tdata,   // u1_code, u2_code
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [bmg_pkg::M_TDATA_W-1:0]       m_tdata,   // sample
    output logic                                m_tlast,   // is_last
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bmg_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bmg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [31:0] FULL = 32'((64'd1 << UNIFORM_BITS) - 64'd1);
    localparam logic [34:0] LOG2_FULL = bmg_pkg::log2_q30(FULL);

    logic signed [19:0] mean_reg;
    logic [15:0]        sdev_reg;

    logic [UNIFORM_BITS-1:0] c1, c2;
    logic [31:0] phase_rep, phase;
    logic [29:0] frac;
    logic        adv, obuf_load;

    bmg_pkg::bmg_pipe_t in_reg, in_next;
    bmg_pkg::bmg_pipe_t nrm_reg [0:4];
    bmg_pkg::bmg_pipe_t nrm_next [0:4];
    bmg_pkg::bmg_pipe_t prep_reg, prep_next;
    bmg_pkg::bmg_pipe_t log_bus [0:30];
    bmg_pkg::bmg_pipe_t diff_reg, diff_next;
    bmg_pkg::bmg_pipe_t mul_reg, mul_next;
    bmg_pkg::bmg_pipe_t vsum_reg, vsum_next;
    bmg_pkg::bmg_pipe_t sqrt_bus [0:27];
    bmg_pkg::bmg_pipe_t tay_bus [0:7];
    bmg_pkg::bmg_pipe_t fold_reg, fold_next;
    bmg_pkg::bmg_pipe_t mprod_reg, mprod_next;
    bmg_pkg::bmg_pipe_t wprod_reg, wprod_next;

    logic        obuf_vld_reg, obuf_idx_reg;
    logic [19:0] cos_reg, sin_reg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg <= bmg_pkg::MEAN_RESET;
            sdev_reg <= bmg_pkg::SDEV_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bmg_pkg::CFG_NOISE_MEAN: begin
                    mean_reg <= cfg_data[19:0];
                end
                bmg_pkg::CFG_NOISE_SDEV: begin
                    sdev_reg <= cfg_data[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // flow control
    assign obuf_load = !obuf_vld_reg || (m_tready && obuf_idx_reg);
    assign adv = !wprod_reg.vld || obuf_load;
    assign s_tready = adv;

    // entry: phase is the code repeated as a binary fraction
    assign c1 = s_tdata[UNIFORM_BITS-1:0];
    assign c2 = s_tdata[2*UNIFORM_BITS-1:UNIFORM_BITS];

    for (genvar i = 0; i < 32; i++) begin : g_phase
        assign phase_rep[31-i] = c2[UNIFORM_BITS-1-(i % UNIFORM_BITS)];
    end

    assign phase = (c2 == FULL[UNIFORM_BITS-1:0]) ? 32'd0 : phase_rep;
    assign frac = phase[29:0];

    always_comb begin
        in_next = '0;
        in_next.vld = s_tvalid && (c1 != '0);
        in_next.xn = 32'(c1);
        in_next.quad = bmg_pkg::bmg_quad_t'(phase[31:30]);
        in_next.swp = frac > bmg_pkg::Q30_HALF;
        in_next.g = in_next.swp ? 30'(bmg_pkg::Q30_ONE - 31'(frac)) : frac;
    end

    // leading-zero normalization
    for (genvar k = 0; k < 5; k++) begin : g_norm
        localparam int SH = 16 >> k;
        bmg_pkg::bmg_pipe_t src;
        if (k == 0) begin : g_first
            assign src = in_reg;
        end else begin : g_rest
            assign src = nrm_reg[k-1];
        end
        always_comb begin
            nrm_next[k] = src;
            if (src.xn[31 -: SH] == '0) begin
                nrm_next[k].xn = src.xn << SH;
                nrm_next[k].zc = src.zc | 5'(SH);
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nrm_reg[k].vld <= 1'b0;
            end else if (adv) begin
                nrm_reg[k] <= nrm_next[k];
            end
        end
    end

    // mantissa, exponent and angle
    always_comb begin
        prep_next = nrm_reg[4];
        prep_next.lm = nrm_reg[4].xn[31:1];
        prep_next.lres = {5'd31 - nrm_reg[4].zc, 30'd0};
        prep_next.x = 30'((61'(nrm_reg[4].g) * 61'(bmg_pkg::PIH_Q30)) >> 30);
    end

    assign log_bus[0] = prep_reg;

    for (genvar i = 0; i < 30; i++) begin : g_log
        bmg_log_cell #(
            .FRAC_BIT(29 - i)
        ) u_log_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .pipe_i  (log_bus[i]),
            .pipe_o  (log_bus[i+1])
        );
    end

    // -ln u1 path
    always_comb begin
        logic [35:0] d;
        diff_next = log_bus[30];
        d = {1'b0, LOG2_FULL} - {1'b0, log_bus[30].lres};
        diff_next.lv = d[35] ? 35'd0 : d[34:0];
        diff_next.x2 = 30'((60'(log_bus[30].x) * 60'(log_bus[30].x)) >> 30);
    end

    always_comb begin
        mul_next = diff_reg;
        mul_next.vi = 36'(diff_reg.lv[34:30]) * 36'(bmg_pkg::TWO_LN2_Q30);
        mul_next.vf = 61'(diff_reg.lv[29:0]) * 61'(bmg_pkg::TWO_LN2_Q30);
    end

    always_comb begin
        logic [35:0] v;
        vsum_next = mul_reg;
        v = mul_reg.vi + 36'(mul_reg.vf[60:30]);
        vsum_next.sn = {v, 18'd0};
        vsum_next.sr = '0;
        vsum_next.ts = 31'(mul_reg.x);
        vsum_next.tc = bmg_pkg::Q30_ONE;
        vsum_next.s = 32'(mul_reg.x);
        vsum_next.c = 32'(bmg_pkg::Q30_ONE);
    end

    assign sqrt_bus[0] = vsum_reg;

    for (genvar j = 0; j < 27; j++) begin : g_sqrt
        bmg_sqrt_cell #(
            .BIT_POS(52 - 2 * j)
        ) u_sqrt_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .pipe_i  (sqrt_bus[j]),
            .pipe_o  (sqrt_bus[j+1])
        );
    end

    assign tay_bus[0] = sqrt_bus[27];

    for (genvar k = 1; k <= 7; k++) begin : g_taylor
        bmg_taylor_cell #(
            .SIN_DIV  ((2 * k) * (2 * k + 1)),
            .COS_DIV  ((2 * k - 1) * (2 * k)),
            .SUBTRACT (k % 2 == 1)
        ) u_taylor_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .pipe_i  (tay_bus[k-1]),
            .pipe_o  (tay_bus[k])
        );
    end

    // quadrant fold
    always_comb begin
        logic signed [31:0] sa, ca, cosv, sinv;
        fold_next = tay_bus[7];
        sa = tay_bus[7].swp ? tay_bus[7].c : tay_bus[7].s;
        ca = tay_bus[7].swp ? tay_bus[7].s : tay_bus[7].c;
        case (tay_bus[7].quad)
            bmg_pkg::QUAD_0: begin
                cosv = ca;
                sinv = sa;
            end
            bmg_pkg::QUAD_1: begin
                cosv = -sa;
                sinv = ca;
            end
            bmg_pkg::QUAD_2: begin
                cosv = -ca;
                sinv = -sa;
            end
            bmg_pkg::QUAD_3: begin
                cosv = sa;
                sinv = -ca;
            end
            default: begin
                cosv = ca;
                sinv = sa;
            end
        endcase
        fold_next.cneg = cosv < 0;
        fold_next.sneg = sinv < 0;
        fold_next.cmag = 31'(fold_next.cneg ? -cosv : cosv);
        fold_next.smag = 31'(fold_next.sneg ? -sinv : sinv);
    end

    always_comb begin
        mprod_next = fold_reg;
        mprod_next.cm = 28'((58'(fold_reg.sr[26:0]) * 58'(fold_reg.cmag)) >> 30);
        mprod_next.sm = 28'((58'(fold_reg.sr[26:0]) * 58'(fold_reg.smag)) >> 30);
    end

    always_comb begin
        wprod_next = mprod_reg;
        wprod_next.wcos = 44'(mprod_reg.cm) * 44'(sdev_reg);
        wprod_next.wsin = 44'(mprod_reg.sm) * 44'(sdev_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.vld <= 1'b0;
            prep_reg.vld <= 1'b0;
            diff_reg.vld <= 1'b0;
            mul_reg.vld <= 1'b0;
            vsum_reg.vld <= 1'b0;
            fold_reg.vld <= 1'b0;
            mprod_reg.vld <= 1'b0;
            wprod_reg.vld <= 1'b0;
        end else if (adv) begin
            in_reg <= in_next;
            prep_reg <= prep_next;
            diff_reg <= diff_next;
            mul_reg <= mul_next;
            vsum_reg <= vsum_next;
            fold_reg <= fold_next;
            mprod_reg <= mprod_next;
            wprod_reg <= wprod_next;
        end
    end

    // sign, mean, round to nearest, saturate
    function automatic logic [19:0] round_sat(input logic [43:0] wmag, input logic neg,
                                              input logic signed [19:0] mean);
        logic signed [45:0] w;
        logic signed [21:0] rs;
        logic [19:0]        res;
        w = neg ? -$signed({2'b00, wmag}) : $signed({2'b00, wmag});
        w = w + ($signed(46'(mean)) <<< 24) + 46'sd8388608;
        rs = w[45:24];
        if (rs > bmg_pkg::SAMPLE_MAX) begin
            res = 20'h7FFFF;
        end else if (rs < bmg_pkg::SAMPLE_MIN) begin
            res = 20'h80000;
        end else begin
            res = rs[19:0];
        end
        return res;
    endfunction

    // output register, cosine then sine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            obuf_vld_reg <= 1'b0;
            obuf_idx_reg <= 1'b0;
        end else if (obuf_load) begin
            obuf_vld_reg <= wprod_reg.vld;
            obuf_idx_reg <= 1'b0;
        end else if (m_tready) begin
            obuf_idx_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (obuf_load) begin
            cos_reg <= round_sat(wprod_reg.wcos, wprod_reg.cneg, mean_reg);
            sin_reg <= round_sat(wprod_reg.wsin, wprod_reg.sneg, mean_reg);
        end
    end

    assign m_tvalid = obuf_vld_reg;
    assign m_tlast = obuf_idx_reg;
    assign m_tdata = {4'd0, obuf_idx_reg ? sin_reg : cos_reg};

endmodule

// ===== hdl/bmg_checker.sv =====
`include "box_muller_gaussian_noise_defines.svh"

module bmg_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bmg_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                              m_tlast
);

    // output empty right after reset
    `BMG_ASSERT_NEXT_ALL(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // a cosine transaction is always followed by its sine sample
    `BMG_ASSERT_NEXT(a_sine_follows, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast)

    // the sine sample only shows up after a cosine transaction
    `BMG_ASSERT_SAME(a_sine_after_cos, aclk, aresetn, $rose(m_tlast), $past(m_tvalid && m_tready))

    // stalled result holds
    `BMG_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind box_muller_gaussian_noise bmg_checker u_bmg_checker (.*);

// ===== tb/sv/tb_box_muller_gaussian_noise.sv =====
module tb_box_muller_gaussian_noise;

    localparam int UB = 16;
    localparam logic [UB-1:0] FULL_CODE = '1;
    localparam logic [63:0] LN2X2 = 64'd1488522236;
    localparam logic [63:0] PIH = 64'd1686629713;
    localparam logic [63:0] ONE30 = 64'd1 << 30;
    localparam int SMP_MAX = 524287;
    localparam int SMP_MIN = -524288;
    localparam int NUM_RANDOM = 1600;
    localparam int DRAIN_CYCLES = 150;

    typedef struct packed {
        logic [bmg_pkg::SAMPLE_W-1:0] sample;
        logic                         is_last;
    } noise_sample_t;

    typedef struct {
        logic [UB-1:0] u1;
        logic [UB-1:0] u2;
        logic          fixed_exp;
        logic [19:0]   exp_cos;
        logic [19:0]   exp_sin;
    } pair_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [2*UB-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [bmg_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bmg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bmg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    box_muller_gaussian_noise #(.UNIFORM_BITS(UB)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 aclk = ~aclk;

    longint signed mean_q12 = 0;
    longint unsigned sdev_q12 = 2048;
    noise_sample_t pending_samples[$];
    int mismatches = 0;
    int sink_gap = 0;
    bit quiet_phase = 1'b0;

    function automatic longint unsigned log2_fix(longint unsigned x);
        int e;
        longint unsigned m, res;
        e = 0;
        for (int i = 0; i < 64; i++) if (x >> i != 0) e = i;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        res = longint'(e) << 30;
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (ONE30 << 1)) begin
                m = m >> 1;
                res = res | (64'd1 << i);
            end
        end
        return res;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [19:0] scale_sample(longint unsigned r24, longint signed trig);
        longint unsigned mag, m24;
        longint signed w, res;
        mag = trig < 0 ? -trig : trig;
        m24 = (r24 * mag) >> 30;
        w = m24 * sdev_q12;
        if (trig < 0) w = -w;
        w = w + mean_q12 * 64'sd16777216;
        res = (w + (64'sd1 <<< 23)) >>> 24;
        if (res > SMP_MAX) res = SMP_MAX;
        if (res < SMP_MIN) res = SMP_MIN;
        return res[19:0];
    endfunction

    task automatic predict_gaussian_pair(input logic [UB-1:0] u1, input logic [UB-1:0] u2);
        longint unsigned full, lval, v, r24, p, f, g, x, x2, ts, tc;
        longint signed diff, s, c, sa, ca, cv, sv;
        bmg_pkg::bmg_quad_t quad;
        full = FULL_CODE;
        if (u1 == 0) return;
        diff = longint'(log2_fix(full)) - longint'(log2_fix(u1));
        lval = diff < 0 ? 0 : diff;
        v = (lval >> 30) * LN2X2 + (((lval & (ONE30 - 1)) * LN2X2) >> 30);
        r24 = int_sqrt(v << 18);
        p = ((longint'(u2) << 32) / full) & 64'hFFFF_FFFF;
        quad = bmg_pkg::bmg_quad_t'(p[31:30]);
        f = p & (ONE30 - 1);
        g = (f > (ONE30 >> 1)) ? ONE30 - f : f;
        x = (g * PIH) >> 30;
        x2 = (x * x) >> 30;
        ts = x;
        tc = ONE30;
        s = x;
        c = ONE30;
        for (int k = 1; k <= 7; k++) begin
            ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s = s - longint'(ts);
                c = c - longint'(tc);
            end else begin
                s = s + longint'(ts);
                c = c + longint'(tc);
            end
        end
        if (f > (ONE30 >> 1)) begin
            sa = c;
            ca = s;
        end else begin
            sa = s;
            ca = c;
        end
        case (quad)
            bmg_pkg::QUAD_0: begin cv = ca; sv = sa; end
            bmg_pkg::QUAD_1: begin cv = -sa; sv = ca; end
            bmg_pkg::QUAD_2: begin cv = -ca; sv = -sa; end
            default: begin cv = sa; sv = -ca; end
        endcase
        pending_samples.push_back('{scale_sample(r24, cv), 1'b0});
        pending_samples.push_back('{scale_sample(r24, sv), 1'b1});
    endtask

    // source gap: now and then, outside the quiet phase, drop tvalid and hold it low for a burst
    task automatic idle_burst();
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    task automatic send_pair(input logic [UB-1:0] u1, input logic [UB-1:0] u2);
        s_tvalid <= 1'b1;
        s_tdata <= {u2, u1};
        do @(posedge aclk); while (!s_tready);
        predict_gaussian_pair(u1, u2);
        idle_burst();
    endtask

    task automatic write_reg(input logic [bmg_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [19:0] val);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == bmg_pkg::CFG_NOISE_MEAN) mean_q12 = $signed(val);
        else if (idx == bmg_pkg::CFG_NOISE_SDEV) sdev_q12 = val[15:0];
    endtask

    // sink side: stall bursts and field-by-field compare
    always @(posedge aclk) begin
        noise_sample_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction sample=%h last=%b",
                                 m_tdata[19:0], m_tlast);
                end else begin
                    want = pending_samples.pop_front();
                    if (m_tdata[19:0] !== want.sample || m_tlast !== want.is_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected sample=%h last=%b, got %h %b",
                                     want.sample, want.is_last, m_tdata[19:0], m_tlast);
                    end
                end
            end
            if (quiet_phase) begin
                sink_gap = 0;
                m_tready <= 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    pair_row_t directed[] = '{
        '{16'hFFFF, 16'h0000, 1'b1, 20'h00000, 20'h00000},
        '{16'hFFFF, 16'h1234, 1'b1, 20'h00000, 20'h00000},
        '{16'h0000, 16'h5555, 1'b0, 20'h0, 20'h0},
        '{16'h0001, 16'h0000, 1'b0, 20'h0, 20'h0},
        '{16'h0001, 16'hFFFF, 1'b0, 20'h0, 20'h0},
        '{16'h0001, 16'h4000, 1'b0, 20'h0, 20'h0},
        '{16'h0001, 16'h8000, 1'b0, 20'h0, 20'h0},
        '{16'h0001, 16'hC000, 1'b0, 20'h0, 20'h0},
        '{16'h8000, 16'h2000, 1'b0, 20'h0, 20'h0},
        '{16'h5555, 16'hAAAA, 1'b0, 20'h0, 20'h0},
        '{16'hAAAA, 16'h5555, 1'b0, 20'h0, 20'h0},
        '{16'h0002, 16'h7FFF, 1'b0, 20'h0, 20'h0},
        '{16'hFFFE, 16'hE000, 1'b0, 20'h0, 20'h0}
    };

    task automatic run_phase(input int n);
        logic [UB-1:0] a;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: a = UB'($urandom_range(0, 8));
                1: a = FULL_CODE - UB'($urandom_range(0, 3));
                default: a = UB'($urandom);
            endcase
            send_pair(a, UB'($urandom));
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed[i]) begin
            if (directed[i].fixed_exp) begin
                send_pair(directed[i].u1, directed[i].u2);
                void'(pending_samples.pop_back());
                void'(pending_samples.pop_back());
                pending_samples.push_back('{directed[i].exp_cos, 1'b0});
                pending_samples.push_back('{directed[i].exp_sin, 1'b1});
            end else begin
                send_pair(directed[i].u1, directed[i].u2);
            end
        end
        s_tvalid <= 1'b0;
        // extremes of both registers, with overflow into saturation
        write_reg(bmg_pkg::CFG_NOISE_SDEV, 20'h0FFFF);
        write_reg(bmg_pkg::CFG_NOISE_MEAN, 20'h7FFFF);
        run_phase(40);
        write_reg(bmg_pkg::CFG_NOISE_MEAN, 20'h80000);
        run_phase(40);
        write_reg(bmg_pkg::CFG_NOISE_SDEV, 20'h00000);
        send_pair(16'h0001, 16'h1111);
        s_tvalid <= 1'b0;
        write_reg(bmg_pkg::CFG_NOISE_MEAN, 20'h00000);
        write_reg(bmg_pkg::CFG_NOISE_SDEV, 20'h01000);
        write_reg(8'd7, 20'h12345);
        run_phase(NUM_RANDOM / 2);
        write_reg(bmg_pkg::CFG_NOISE_MEAN, 20'($urandom));
        write_reg(bmg_pkg::CFG_NOISE_SDEV, 20'($urandom_range(0, 16'h3000)));
        run_phase(NUM_RANDOM / 4);
        quiet_phase = 1'b1;
        write_reg(bmg_pkg::CFG_NOISE_SDEV, 20'(bmg_pkg::SDEV_RESET));
        write_reg(bmg_pkg::CFG_NOISE_MEAN, bmg_pkg::MEAN_RESET);
        run_phase(NUM_RANDOM / 4);
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bmg_pkg.sv
hdl/bmg_log_cell.sv
hdl/bmg_sqrt_cell.sv
hdl/bmg_taylor_cell.sv
hdl/box_muller_gaussian_noise.sv
hdl/bmg_checker.sv
tb/sv/tb_box_muller_gaussian_noise.sv
